@@ rtl/bcc_pkg.sv @@
// Shared types, codes and reset values for the button click classifier.
package bcc_pkg;

    // Widths of the configuration port and the payload fields.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int CNT_W      = 8;
    localparam int EVENT_W    = 3;
    localparam int PHASE_W    = 2;

    // Register reset values.
    localparam logic [CNT_W-1:0] LONG_THR_RST   = 8'd8;
    localparam logic [CNT_W-1:0] DBL_WIN_RST    = 8'd7;
    localparam logic             REPEAT_EN_RST  = 1'b0;
    localparam logic [CNT_W-1:0] REPEAT_TCK_RST = 8'd10;
    localparam logic [CNT_W-1:0] LONG_CLR_RST   = 8'd30;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_THR   = 3'd0,
        CFG_DBL_WIN    = 3'd1,
        CFG_REPEAT_EN  = 3'd2,
        CFG_REPEAT_TCK = 3'd3,
        CFG_LONG_CLR   = 3'd4
    } t_cfg_idx;

    // Event codes reported with each result beat.
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_SHORT     = 3'd1,
        EV_DOUBLE    = 3'd2,
        EV_LONG      = 3'd3,
        EV_LONG_HELD = 3'd4
    } t_event;

    // Press phase codes.
    typedef enum logic [PHASE_W-1:0] {
        PH_UP    = 2'd0,
        PH_DOWN  = 2'd1,
        PH_SHORT = 2'd2,
        PH_LONG  = 2'd3
    } t_phase;

    // Scan sequence steps; codes five to seven are unused.
    typedef enum logic [2:0] {
        SC_IDLE    = 3'd0,
        SC_HELD    = 3'd1,
        SC_SETTLE  = 3'd2,
        SC_RELCHK  = 3'd3,
        SC_SECOND  = 3'd4
    } t_scan_step;

    // Register set handed from the configuration block to the scan logic.
    typedef struct packed {
        logic [CNT_W-1:0] long_thr;
        logic [CNT_W-1:0] dbl_win;
        logic             repeat_en;
        logic [CNT_W-1:0] repeat_tck;
        logic [CNT_W-1:0] long_clr;
    } t_cfg;

    // Increment that sticks at the top of the counter range.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

@@ rtl/bcc_if.sv @@
// Handshake channel interfaces for the button click classifier.

// Input channel: one sampled pin level per beat.
interface bcc_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

// Result channel: one event and press phase per beat.
interface bcc_out_if;
    logic                      valid;
    logic                      ready;
    logic [bcc_pkg::EVENT_W-1:0] event_res;
    logic [bcc_pkg::PHASE_W-1:0] press_state;

    modport source (output valid, output event_res, output press_state, input ready);
    modport sink   (input valid, input event_res, input press_state, output ready);
endinterface

// Configuration write channel.
interface bcc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bcc_pkg::CFG_IDX_W-1:0]  index;
    logic [bcc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/bcc_cfg.sv @@
// Configuration register file of the button click classifier.
module bcc_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bcc_cfg_if.sink        i_cfg,
    output bcc_pkg::t_cfg  o_cfg
);

    logic [bcc_pkg::CNT_W-1:0] r_long_thr;
    logic [bcc_pkg::CNT_W-1:0] r_dbl_win;
    logic                      r_repeat_en;
    logic [bcc_pkg::CNT_W-1:0] r_repeat_tck;
    logic [bcc_pkg::CNT_W-1:0] r_long_clr;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_thr   <= bcc_pkg::LONG_THR_RST;
            r_dbl_win    <= bcc_pkg::DBL_WIN_RST;
            r_repeat_en  <= bcc_pkg::REPEAT_EN_RST;
            r_repeat_tck <= bcc_pkg::REPEAT_TCK_RST;
            r_long_clr   <= bcc_pkg::LONG_CLR_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bcc_pkg::CFG_LONG_THR:   r_long_thr   <= i_cfg.data;
                bcc_pkg::CFG_DBL_WIN:    r_dbl_win    <= i_cfg.data;
                bcc_pkg::CFG_REPEAT_EN:  r_repeat_en  <= i_cfg.data[0];
                bcc_pkg::CFG_REPEAT_TCK: r_repeat_tck <= i_cfg.data;
                bcc_pkg::CFG_LONG_CLR:   r_long_clr   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_cfg = '{long_thr:   r_long_thr,
                     dbl_win:    r_dbl_win,
                     repeat_en:  r_repeat_en,
                     repeat_tck: r_repeat_tck,
                     long_clr:   r_long_clr};

endmodule

@@ rtl/bcc_scan.sv @@
// Scan sequence, press state and counters of the button click classifier.
module bcc_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_pressed,
    input  bcc_pkg::t_cfg        i_cfg,
    output bcc_pkg::t_event      o_event,
    output bcc_pkg::t_phase      o_phase
);

    bcc_pkg::t_scan_step       r_step,    n_step;
    bcc_pkg::t_phase           r_phase,   n_phase;
    logic [bcc_pkg::CNT_W-1:0] r_hold,    n_hold;
    logic [bcc_pkg::CNT_W-1:0] r_window,  n_window;
    logic                      r_long,    n_long;
    logic [bcc_pkg::CNT_W-1:0] r_release, n_release;

    logic [bcc_pkg::CNT_W-1:0] w_rel_inc;
    logic [bcc_pkg::CNT_W-1:0] w_hold_inc;
    logic                      w_hold_short;
    logic                      w_rel_after;

    // The release counter advances on every tick before the scan step.
    assign w_rel_inc    = bcc_pkg::sat_inc(r_release);
    assign w_hold_inc   = bcc_pkg::sat_inc(r_hold);
    assign w_hold_short = (w_hold_inc < i_cfg.long_thr);

    // Next scan step.
    always_comb begin
        n_step = r_step;
        unique case (r_step)
            bcc_pkg::SC_IDLE: begin
                if (i_pressed) begin
                    n_step = (r_window != '0) ? bcc_pkg::SC_SECOND : bcc_pkg::SC_SETTLE;
                end
            end
            bcc_pkg::SC_HELD: begin
                if (!i_pressed) begin
                    n_step = bcc_pkg::SC_SETTLE;
                end
            end
            bcc_pkg::SC_SETTLE: begin
                n_step = i_pressed ? bcc_pkg::SC_HELD : bcc_pkg::SC_RELCHK;
            end
            bcc_pkg::SC_RELCHK: begin
                n_step = i_pressed ? bcc_pkg::SC_SETTLE : bcc_pkg::SC_IDLE;
            end
            bcc_pkg::SC_SECOND: begin
                if (!i_pressed) begin
                    n_step = bcc_pkg::SC_IDLE;
                end
            end
            default: n_step = bcc_pkg::SC_IDLE;
        endcase
    end

    // Event, phase and counter updates for this tick.
    always_comb begin
        o_event     = bcc_pkg::EV_NONE;
        n_phase     = r_phase;
        n_hold      = r_hold;
        n_window    = r_window;
        n_long      = r_long;
        w_rel_after = 1'b0;
        n_release   = w_rel_inc;
        unique case (r_step)
            bcc_pkg::SC_IDLE: begin
                if (i_pressed) begin
                    n_phase = bcc_pkg::PH_DOWN;
                end else if (r_window != '0) begin
                    n_window = r_window - 1'b1;
                    if (r_window == 8'd1 && r_phase == bcc_pkg::PH_SHORT) begin
                        o_event = r_long ? bcc_pkg::EV_LONG_HELD : bcc_pkg::EV_SHORT;
                        n_phase = bcc_pkg::PH_UP;
                    end
                end else begin
                    n_hold = '0;
                end
            end
            bcc_pkg::SC_HELD: begin
                if (i_pressed) begin
                    if (w_hold_short) begin
                        n_hold  = w_hold_inc;
                        n_phase = bcc_pkg::PH_SHORT;
                    end else if (r_long) begin
                        // A further long-length hold while the long flag is set.
                        o_event = bcc_pkg::EV_LONG_HELD;
                        n_phase = bcc_pkg::PH_UP;
                        if (i_cfg.repeat_en) begin
                            n_hold = i_cfg.long_thr;
                            if (w_rel_inc >= i_cfg.repeat_tck) begin
                                o_event   = bcc_pkg::EV_LONG;
                                n_phase   = bcc_pkg::PH_LONG;
                                n_long    = 1'b1;
                                n_release = '0;
                            end
                        end else begin
                            n_hold    = '0;
                            n_release = '0;
                        end
                    end else begin
                        o_event   = bcc_pkg::EV_LONG;
                        n_phase   = bcc_pkg::PH_LONG;
                        n_long    = 1'b1;
                        n_release = '0;
                        n_hold    = i_cfg.long_thr;
                    end
                end
            end
            bcc_pkg::SC_RELCHK: begin
                if (!i_pressed) begin
                    if (r_hold < i_cfg.long_thr) begin
                        n_window = i_cfg.dbl_win;
                    end
                    n_hold = '0;
                end
            end
            bcc_pkg::SC_SECOND: begin
                if (!i_pressed) begin
                    n_phase = bcc_pkg::PH_UP;
                    o_event = bcc_pkg::EV_DOUBLE;
                end
            end
            default: ;
        endcase
        // The long flag clears once the release counter reaches its limit.
        if (n_release >= i_cfg.long_clr) begin
            w_rel_after = 1'b1;
            n_release   = '0;
            n_long      = 1'b0;
        end
    end

    assign o_phase = n_phase;

    // State registers advance once per accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= bcc_pkg::SC_IDLE;
            r_phase   <= bcc_pkg::PH_UP;
            r_hold    <= '0;
            r_window  <= '0;
            r_long    <= 1'b0;
            r_release <= '0;
        end else if (i_step) begin
            r_step    <= n_step;
            r_phase   <= n_phase;
            r_hold    <= n_hold;
            r_window  <= n_window;
            r_long    <= n_long && !w_rel_after;
            r_release <= n_release;
        end
    end

endmodule

@@ rtl/button_click_classifier_unit.sv @@
// Top level of the button click classifier: handshake, output register and assertions.
// A result beat is registered and offered in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; the single output register holds a result
// while the sink stalls and takes the next one as soon as it is read.
// Reset: synchronous, active low; clears the scan state, counters and output valid
// and loads the register defaults. No clearing pass is needed.
module button_click_classifier_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bcc_in_if.sink   i_in,
    bcc_out_if.source o_out,
    bcc_cfg_if.sink  i_cfg
);

    bcc_pkg::t_cfg   w_cfg;
    bcc_pkg::t_event w_event;
    bcc_pkg::t_phase w_phase;
    logic            w_accept;

    logic                        r_out_valid;
    logic [bcc_pkg::EVENT_W-1:0] r_event;
    logic [bcc_pkg::PHASE_W-1:0] r_phase;

    // Register file.
    bcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // A new beat is taken whenever the output register is empty or being read.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Scan logic, stepped once per accepted beat.
    bcc_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_accept),
        .i_pressed (!i_in.pin_level),
        .i_cfg     (w_cfg),
        .o_event   (w_event),
        .o_phase   (w_phase)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_event <= w_event;
            r_phase <= w_phase;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.event_res   = r_event;
    assign o_out.press_state = r_phase;

`ifndef NO_ASSERTIONS
    // A stalled result blocks the input side.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while a result is stalled");

    // Every accepted beat yields a result in the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out.valid)
        else $error("accepted beat produced no result");

    // A double click always ends with the button up.
    a_double_is_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.event_res == bcc_pkg::EV_DOUBLE)
            |-> o_out.press_state == bcc_pkg::PH_UP)
        else $error("double event without up phase");

    // A long event always reports the long phase.
    a_long_is_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.event_res == bcc_pkg::EV_LONG)
            |-> o_out.press_state == bcc_pkg::PH_LONG)
        else $error("long event without long phase");
`endif

endmodule
